@@ sv/cia_pkg.sv @@
package cia_pkg;

  localparam int RES_W = 33;

  typedef enum logic [1:0] {
    CMD_ADD,
    CMD_SUB,
    CMD_MUL,
    CMD_DIV
  } cia_cmd_t;

  typedef struct packed {
    logic             is_div;
    logic             dz;
    logic             neg_re;
    logic             neg_im;
    logic [RES_W-1:0] res_re;
    logic [RES_W-1:0] res_im;
  } cia_ctl_t;

endpackage

@@ sv/cia_in_if.sv @@
interface cia_in_if #(
  parameter int W = 16
);
  logic                valid;
  logic                ready;
  logic [1:0]          command;
  logic signed [W-1:0] a_real;
  logic signed [W-1:0] a_imag;
  logic signed [W-1:0] b_real;
  logic signed [W-1:0] b_imag;

  modport source(output valid, command, a_real, a_imag, b_real, b_imag, input ready);
  modport sink(input valid, command, a_real, a_imag, b_real, b_imag, output ready);
endinterface

@@ sv/cia_out_if.sv @@
interface cia_out_if import cia_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [RES_W-1:0] result_real;
  logic signed [RES_W-1:0] result_imag;
  logic                    divide_by_zero;

  modport source(output valid, result_real, result_imag, divide_by_zero, input ready);
  modport sink(input valid, result_real, result_imag, divide_by_zero, output ready);
endinterface

@@ sv/cia_front.sv @@
module cia_front import cia_pkg::*; #(
  parameter int W = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [1:0]          command,
  input  logic signed [W-1:0] a_real,
  input  logic signed [W-1:0] a_imag,
  input  logic signed [W-1:0] b_real,
  input  logic signed [W-1:0] b_imag,
  output logic                v_o,
  output cia_ctl_t            ctl_o,
  output logic [2*W-1:0]      mag_re_o,
  output logic [2*W-1:0]      mag_im_o,
  output logic [2*W-1:0]      den_o
);

  localparam int P_W   = 2 * W;
  localparam int S_W   = 2 * W + 1;
  localparam int EXT_W = 2 * W + RES_W;

  logic                  v1_r;
  cia_cmd_t              cmd1_r;
  logic                  dz1_r;
  logic signed [P_W-1:0] prr_r, pii_r, pri_r, pir_r, sqr_r, sqi_r;
  logic signed [W:0]     sre_r, sim_r;

  logic                  v2_r;
  cia_ctl_t              ctl2_r, ctl2_nxt;
  logic [P_W-1:0]        mre2_r, mim2_r, den2_r;
  logic [P_W-1:0]        mre2_nxt, mim2_nxt, den2_nxt;

  logic signed [S_W-1:0]   num_re, num_im, mul_re, mul_im, abs_re, abs_im;
  logic signed [EXT_W-1:0] ext_re, ext_im;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd1_r <= cia_cmd_t'(command);
      dz1_r  <= (b_real == '0) && (b_imag == '0);
      prr_r  <= P_W'(a_real) * P_W'(b_real);
      pii_r  <= P_W'(a_imag) * P_W'(b_imag);
      pri_r  <= P_W'(a_real) * P_W'(b_imag);
      pir_r  <= P_W'(a_imag) * P_W'(b_real);
      sqr_r  <= P_W'(b_real) * P_W'(b_real);
      sqi_r  <= P_W'(b_imag) * P_W'(b_imag);
      if (cia_cmd_t'(command) == CMD_SUB) begin
        sre_r <= {a_real[W-1], a_real} - {b_real[W-1], b_real};
        sim_r <= {a_imag[W-1], a_imag} - {b_imag[W-1], b_imag};
      end else begin
        sre_r <= {a_real[W-1], a_real} + {b_real[W-1], b_real};
        sim_r <= {a_imag[W-1], a_imag} + {b_imag[W-1], b_imag};
      end
      ctl2_r <= ctl2_nxt;
      mre2_r <= mre2_nxt;
      mim2_r <= mim2_nxt;
      den2_r <= den2_nxt;
    end
  end

  always_comb begin
    num_re   = S_W'(prr_r) + S_W'(pii_r);
    num_im   = S_W'(pir_r) - S_W'(pri_r);
    mul_re   = S_W'(prr_r) - S_W'(pii_r);
    mul_im   = S_W'(pri_r) + S_W'(pir_r);
    abs_re   = num_re[S_W-1] ? -num_re : num_re;
    abs_im   = num_im[S_W-1] ? -num_im : num_im;
    mre2_nxt = abs_re[P_W-1:0];
    mim2_nxt = abs_im[P_W-1:0];
    den2_nxt = sqr_r[P_W-1:0] + sqi_r[P_W-1:0];
    ext_re   = '0;
    ext_im   = '0;
    case (cmd1_r)
      CMD_ADD, CMD_SUB: begin
        ext_re = EXT_W'(sre_r);
        ext_im = EXT_W'(sim_r);
      end
      CMD_MUL: begin
        ext_re = EXT_W'(mul_re);
        ext_im = EXT_W'(mul_im);
      end
      default: begin
        ext_re = '0;
        ext_im = '0;
      end
    endcase
    ctl2_nxt.is_div = (cmd1_r == CMD_DIV);
    ctl2_nxt.dz     = (cmd1_r == CMD_DIV) && dz1_r;
    ctl2_nxt.neg_re = num_re[S_W-1];
    ctl2_nxt.neg_im = num_im[S_W-1];
    ctl2_nxt.res_re = ext_re[RES_W-1:0];
    ctl2_nxt.res_im = ext_im[RES_W-1:0];
  end

  assign v_o      = v2_r;
  assign ctl_o    = ctl2_r;
  assign mag_re_o = mre2_r;
  assign mag_im_o = mim2_r;
  assign den_o    = den2_r;

endmodule

@@ sv/cia_div.sv @@
module cia_div import cia_pkg::*; #(
  parameter int W = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           v_i,
  input  cia_ctl_t       ctl_i,
  input  logic [2*W-1:0] num_re_i,
  input  logic [2*W-1:0] num_im_i,
  input  logic [2*W-1:0] den_i,
  output logic           v_o,
  output cia_ctl_t       ctl_o,
  output logic [2*W-1:0] q_re_o,
  output logic [2*W-1:0] q_im_o
);

  localparam int N = 2 * W;

  logic           v_r   [0:N];
  cia_ctl_t       ctl_r [0:N];
  logic [N-1:0]   den_r [0:N];
  logic [N-1:0]   rre_r [0:N];
  logic [N-1:0]   rim_r [0:N];
  logic [N-1:0]   qre_r [0:N];
  logic [N-1:0]   qim_r [0:N];

  function automatic logic [2*N-1:0] step(input logic [N-1:0] rem,
                                          input logic [N-1:0] nq,
                                          input logic [N-1:0] den);
    logic [N:0] t;
    logic       ge;
    t  = {rem, nq[N-1]};
    ge = t >= {1'b0, den};
    if (ge) begin
      t = t - {1'b0, den};
    end
    return {t[N-1:0], nq[N-2:0], ge};
  endfunction

  always_comb begin
    v_r[0]   = v_i;
    ctl_r[0] = ctl_i;
    den_r[0] = den_i;
    rre_r[0] = '0;
    rim_r[0] = '0;
    qre_r[0] = num_re_i;
    qim_r[0] = num_im_i;
  end

  for (genvar k = 0; k < N; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ctl_r[k+1]                   <= ctl_r[k];
        den_r[k+1]                   <= den_r[k];
        {rre_r[k+1], qre_r[k+1]}     <= step(rre_r[k], qre_r[k], den_r[k]);
        {rim_r[k+1], qim_r[k+1]}     <= step(rim_r[k], qim_r[k], den_r[k]);
      end
    end
  end

  assign v_o    = v_r[N];
  assign ctl_o  = ctl_r[N];
  assign q_re_o = qre_r[N];
  assign q_im_o = qim_r[N];

endmodule

@@ sv/complex_integer_alu_top.sv @@
// Channel  Interface   Role    Payload
// in_ch    cia_in_if   sink    command, a_real, a_imag, b_real, b_imag
// out_ch   cia_out_if  source  result_real, result_imag, divide_by_zero
//
// Every item passes through the front registers, the divider stages and the output
// register from transfer in to result valid, and a new item may enter in every cycle
// while out_ch does not stall. The restoring divider resolves one quotient bit per stage.
// Reset clears the valid bits of all stages and of the output register.
// When a result waits on out_ch, the whole pipeline holds and in_ch is not ready.
module complex_integer_alu_top import cia_pkg::*; #(
  parameter int OPERAND_WIDTH = 16
) (
  input logic              clk,
  input logic              rst_n,
  cia_in_if.sink           in_ch,
  cia_out_if.source        out_ch
);

  localparam int N     = 2 * OPERAND_WIDTH;
  localparam int EXT_W = N + RES_W;

  logic           en;
  logic           fv, dv;
  cia_ctl_t       fctl, dctl;
  logic [N-1:0]   mre, mim, den, qre, qim;

  logic             out_valid_r;
  logic [RES_W-1:0] re_r, im_r, re_nxt, im_nxt;
  logic             dz_r;
  logic [EXT_W-1:0] ext_re, ext_im;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  cia_front #(.W(OPERAND_WIDTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_ch.valid),
    .command  (in_ch.command),
    .a_real   (in_ch.a_real),
    .a_imag   (in_ch.a_imag),
    .b_real   (in_ch.b_real),
    .b_imag   (in_ch.b_imag),
    .v_o      (fv),
    .ctl_o    (fctl),
    .mag_re_o (mre),
    .mag_im_o (mim),
    .den_o    (den)
  );

  cia_div #(.W(OPERAND_WIDTH)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .v_i      (fv),
    .ctl_i    (fctl),
    .num_re_i (mre),
    .num_im_i (mim),
    .den_i    (den),
    .v_o      (dv),
    .ctl_o    (dctl),
    .q_re_o   (qre),
    .q_im_o   (qim)
  );

  always_comb begin
    ext_re = dctl.neg_re ? (EXT_W'(0) - EXT_W'(qre)) : EXT_W'(qre);
    ext_im = dctl.neg_im ? (EXT_W'(0) - EXT_W'(qim)) : EXT_W'(qim);
    if (dctl.dz) begin
      re_nxt = '0;
      im_nxt = '0;
    end else if (dctl.is_div) begin
      re_nxt = ext_re[RES_W-1:0];
      im_nxt = ext_im[RES_W-1:0];
    end else begin
      re_nxt = dctl.res_re;
      im_nxt = dctl.res_im;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      re_r <= re_nxt;
      im_r <= im_nxt;
      dz_r <= dctl.dz;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.result_real    = re_r;
  assign out_ch.result_imag    = im_r;
  assign out_ch.divide_by_zero = dz_r;

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.divide_by_zero |-> out_ch.result_real == '0 &&
    out_ch.result_imag == '0)
    else $error("divide by zero result with nonzero parts");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready == (!out_ch.valid || out_ch.ready))
    else $error("input ready does not follow output stall");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("result valid after reset");

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import cia_pkg::*;

  localparam int OW = 16;
  localparam int LATENCY = 2 * OW + 3;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic [RES_W-1:0] re;
    logic [RES_W-1:0] im;
    logic             dz;
  } cplx_result_t;

  typedef struct {
    cia_cmd_t           cmd;
    logic signed [15:0] ar, ai, br, bi;
    logic               typed;
    cplx_result_t       res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  longint cycles = 0;
  int errors = 0;
  bit in_idle_on = 1'b1;
  bit out_idle_on = 1'b1;
  cplx_result_t pending_results[$];

  cia_in_if #(.W(OW)) in_ch ();
  cia_out_if out_ch ();

  complex_integer_alu_top #(.OPERAND_WIDTH(OW)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic cplx_result_t complex_arith(cia_cmd_t cmd, logic signed [15:0] ar,
      logic signed [15:0] ai, logic signed [15:0] br, logic signed [15:0] bi);
    cplx_result_t r;
    longint sar, sai, sbr, sbi, den, num_re, num_im;
    sar = ar;
    sai = ai;
    sbr = br;
    sbi = bi;
    r.dz = 1'b0;
    r.re = '0;
    r.im = '0;
    case (cmd)
      CMD_ADD: begin
        r.re = RES_W'(sar + sbr);
        r.im = RES_W'(sai + sbi);
      end
      CMD_SUB: begin
        r.re = RES_W'(sar - sbr);
        r.im = RES_W'(sai - sbi);
      end
      CMD_MUL: begin
        r.re = RES_W'(sar * sbr - sai * sbi);
        r.im = RES_W'(sar * sbi + sai * sbr);
      end
      default: begin
        den = sbr * sbr + sbi * sbi;
        if (den == 0) begin
          r.dz = 1'b1;
        end else begin
          num_re = sar * sbr + sai * sbi;
          num_im = sbr * sai - sar * sbi;
          r.re = RES_W'(num_re / den);
          r.im = RES_W'(num_im / den);
        end
      end
    endcase
    return r;
  endfunction

  task automatic send_operands(cia_cmd_t cmd, logic signed [15:0] ar, logic signed [15:0] ai,
      logic signed [15:0] br, logic signed [15:0] bi);
    while (in_idle_on && $urandom_range(99) < 20) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.a_real <= ar;
    in_ch.a_imag <= ai;
    in_ch.b_real <= br;
    in_ch.b_imag <= bi;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic signed [15:0] random_part();
    case ($urandom_range(5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'($urandom_range(6)) - 16'sd3;
      3: return 16'($urandom_range(200)) - 16'sd100;
      default: return 16'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    cplx_result_t want;
    cycles <= cycles + 1;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result re=%0d im=%0d dz=%0b", $time,
                 out_ch.result_real, out_ch.result_imag, out_ch.divide_by_zero);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.result_real !== want.re || out_ch.result_imag !== want.im
            || out_ch.divide_by_zero !== want.dz) begin
          $display("%0t: expected re=%0d im=%0d dz=%0b, actual re=%0d im=%0d dz=%0b",
                   $time, $signed(want.re), $signed(want.im), want.dz,
                   out_ch.result_real, out_ch.result_imag, out_ch.divide_by_zero);
          errors++;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= !(out_idle_on && $urandom_range(99) < 20);
  end

  initial begin
    stim_row_t table_rows[$];
    stim_row_t row;
    cplx_result_t got;
    int tail;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_ADD;
    in_ch.a_real = '0;
    in_ch.a_imag = '0;
    in_ch.b_real = '0;
    in_ch.b_imag = '0;

    table_rows = '{
      '{CMD_ADD, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1, '{33'sd65534, 33'sd65534, 0}},
      '{CMD_ADD, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1,
        '{-33'sd65536, -33'sd65536, 0}},
      '{CMD_SUB, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 1,
        '{33'sd65535, -33'sd65535, 0}},
      '{CMD_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1,
        '{33'sd0, 33'sd2147483648, 0}},
      '{CMD_MUL, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000, 1,
        '{33'sd2147450880, 33'sd32768, 0}},
      '{CMD_DIV, 16'sh7fff, 16'sh8000, 16'sh0000, 16'sh0000, 1, '{33'sd0, 33'sd0, 1}},
      '{CMD_DIV, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 1, '{33'sd0, 33'sd0, 1}},
      '{CMD_DIV, 16'sh8000, 16'sh8000, 16'sh0001, 16'sh0000, 1,
        '{-33'sd32768, -33'sd32768, 0}},
      '{CMD_DIV, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000, 0, '{0, 0, 0}},
      '{CMD_DIV, -16'sd7, 16'sd7, 16'sd2, 16'sd0, 0, '{0, 0, 0}},
      '{CMD_DIV, 16'sd1, 16'sd0, 16'sh7fff, 16'sh7fff, 0, '{0, 0, 0}},
      '{CMD_DIV, 16'sh8000, 16'sh7fff, 16'sd1, 16'sd1, 0, '{0, 0, 0}},
      '{CMD_MUL, -16'sd3, 16'sd5, 16'sd7, -16'sd2, 0, '{0, 0, 0}},
      '{CMD_SUB, 16'sd0, 16'sd0, 16'sh8000, 16'sh8000, 0, '{0, 0, 0}},
      '{CMD_ADD, -16'sd1, 16'sd1, 16'sd1, -16'sd1, 0, '{0, 0, 0}}
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (table_rows[i]) begin
      row = table_rows[i];
      got = complex_arith(row.cmd, row.ar, row.ai, row.br, row.bi);
      pending_results.push_back(row.typed ? row.res : got);
      send_operands(row.cmd, row.ar, row.ai, row.br, row.bi);
    end
    in_ch.valid <= 1'b0;

    // The sender holds off until the pipeline has drained once.
    while (pending_results.size() != 0) @(negedge clk);

    for (int n = 0; n < 1000; n++) begin
      logic signed [15:0] ar, ai, br, bi;
      cia_cmd_t cmd;
      in_idle_on = !(n >= 300 && n < 450);
      out_idle_on = in_idle_on;
      cmd = cia_cmd_t'($urandom_range(3));
      ar = random_part();
      ai = random_part();
      br = random_part();
      bi = random_part();
      if (cmd == CMD_DIV && $urandom_range(19) == 0) begin
        br = '0;
        bi = '0;
      end
      pending_results.push_back(complex_arith(cmd, ar, ai, br, bi));
      send_operands(cmd, ar, ai, br, bi);
    end
    in_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(negedge clk);
    tail = 0;
    while (tail < 2 * LATENCY) begin
      @(negedge clk);
      tail++;
    end
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
sv/cia_pkg.sv
sv/cia_in_if.sv
sv/cia_out_if.sv
sv/cia_front.sv
sv/cia_div.sv
sv/complex_integer_alu_top.sv
tb/sv/tb.sv
